// File: rtl/sine_taylor_series_core_defines.svh
// Assertion macros for the sine series core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SINE_TAYLOR_SERIES_CORE_DEFINES_SVH
`define SINE_TAYLOR_SERIES_CORE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define STSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define STSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/stsc_pkg.sv
// Shared widths, fixed-point constants and the stage bundle of the sine series core.
// No dependencies; every RTL module imports this package.
package stsc_pkg;

  // Port widths.
  localparam int ANGLE_W = 32;
  localparam int SINE_W  = 32;

  // Internal Q.40 format and the width of each quantity.
  localparam int FRAC_W    = 40;
  localparam int MAG_W     = 32;
  localparam int RED_SHIFT = 24;
  localparam int RW        = 43;
  localparam int R2W       = 46;
  localparam int TW        = 47;
  localparam int SW        = 50;

  // Range reduction: estimate quotient = (mag * RED_RCP) >> RCP_SHIFT.
  localparam int QE_W      = 14;
  localparam int RCP_SHIFT = 2 * MAG_W - RED_SHIFT - 8;

  localparam logic [63:0] PI_Q60     = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] TWO_PI_Q40 = ((PI_Q60 >> 18) + 64'd1) >> 1;
  localparam logic [63:0] RED_RECIP  = (64'd1 << (MAG_W + RED_SHIFT)) / TWO_PI_Q40;
  localparam logic [RW-1:0]   TWO_PI  = TWO_PI_Q40[RW-1:0];
  localparam logic [QE_W-1:0] RED_RCP = RED_RECIP[QE_W-1:0];

  // Split points of the partial-product multipliers.
  localparam int SQ_LO_W  = 22;
  localparam int SQ_HI_W  = RW - SQ_LO_W;
  localparam int T_LO_W   = 23;
  localparam int T_HI_W   = TW - T_LO_W;
  localparam int R2_LO_W  = 23;
  localparam int R2_HI_W  = R2W - R2_LO_W;

  // Digit-serial division of a term product by a small constant.
  localparam int PW   = 52;
  localparam int DW   = 13;
  localparam int NDIG = PW / DW;
  localparam int RMW  = 10;
  localparam int VW   = RMW + DW;

  // Output rounding from Q.40 to Q1.30.
  localparam int ROUND_SHIFT = FRAC_W - 30;
  localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);
  localparam logic [SINE_W-1:0] ONE_Q30 = 32'h4000_0000;

  // Bundle that travels down the series pipeline with each transaction.
  typedef struct packed {
    logic                  valid;
    logic                  neg;
    logic [R2W-1:0]        r2;
    logic signed [SW-1:0]  sum;
    logic [TW-1:0]         term;
  } stsc_beat_t;

endpackage

// File: rtl/stsc_reduce.sv
// Front end: angle magnitude, reduction modulo two pi and the square of the reduced angle.
// Depends on stsc_pkg.
module stsc_reduce
  import stsc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [ANGLE_W-1:0] in_angle,
  output stsc_beat_t                beat_o
);

  localparam int RCP_PW = MAG_W + QE_W;
  localparam int DIFF_W = QE_W + RW + 1;
  localparam int SQ_W   = 2 * RW;
  localparam int NSTG   = 6;

  logic [NSTG-1:0] vld_r;

  logic [MAG_W-1:0]        ang_u;
  logic [MAG_W-1:0]        mag1_nxt, mag1_r, mag2_r, mag3_r;
  logic                    neg1_r, neg2_r, neg3_r, neg4_r, neg5_r, neg6_r;
  logic [RCP_PW-1:0]       rcp_prod;
  logic [QE_W-1:0]         qe2_nxt, qe2_r;
  logic [QE_W+RW-1:0]      prod3_nxt, prod3_r;
  logic [DIFF_W-1:0]       x_ext, diff1, diff2;
  logic [RW-1:0]           r4_nxt, r4_r, r5_r, r6_r;
  logic [SQ_LO_W-1:0]      sq_lo;
  logic [SQ_HI_W-1:0]      sq_hi;
  logic [2*SQ_HI_W-1:0]    pp_hh_nxt, pp_hh_r;
  logic [SQ_HI_W+SQ_LO_W-1:0] pp_hl_nxt, pp_hl_r;
  logic [2*SQ_LO_W-1:0]    pp_ll_nxt, pp_ll_r;
  logic [SQ_W-1:0]         sq_full;
  logic [R2W-1:0]          r2_6_nxt, r2_6_r;

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // Stage 1: magnitude of the angle; the most negative angle maps to 2^31 exactly.
  assign ang_u    = in_angle;
  assign mag1_nxt = ang_u[MAG_W-1] ? (~ang_u + 1'b1) : ang_u;

  // Stage 2: quotient estimate by reciprocal multiply, low by at most one.
  assign rcp_prod = mag1_r * RED_RCP;
  assign qe2_nxt  = rcp_prod[RCP_SHIFT +: QE_W];

  // Stage 3: estimated multiple of two pi.
  assign prod3_nxt = qe2_r * TWO_PI;

  // Stage 4: remainder, with one correction when the estimate was one short.
  always_comb begin
    x_ext  = DIFF_W'({mag3_r, {RED_SHIFT{1'b0}}});
    diff1  = x_ext - DIFF_W'(prod3_r);
    diff2  = x_ext - DIFF_W'(prod3_r) - DIFF_W'(TWO_PI);
    r4_nxt = diff2[DIFF_W-1] ? diff1[RW-1:0] : diff2[RW-1:0];
  end

  // Stage 5: partial products of the square.
  assign sq_lo     = r4_r[SQ_LO_W-1:0];
  assign sq_hi     = r4_r[RW-1:SQ_LO_W];
  assign pp_hh_nxt = sq_hi * sq_hi;
  assign pp_hl_nxt = sq_hi * sq_lo;
  assign pp_ll_nxt = sq_lo * sq_lo;

  // Stage 6: sum of the partial products, truncated back to Q.40.
  assign sq_full = (SQ_W'(pp_hh_r) << (2 * SQ_LO_W)) +
                   (SQ_W'(pp_hl_r) << (SQ_LO_W + 1)) +
                   SQ_W'(pp_ll_r);
  assign r2_6_nxt = sq_full[FRAC_W +: R2W];

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= mag1_nxt;
      neg1_r  <= ang_u[MAG_W-1];
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      qe2_r   <= qe2_nxt;
      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
      prod3_r <= prod3_nxt;
      r4_r    <= r4_nxt;
      neg4_r  <= neg3_r;
      r5_r    <= r4_r;
      neg5_r  <= neg4_r;
      pp_hh_r <= pp_hh_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_ll_r <= pp_ll_nxt;
      r6_r    <= r5_r;
      neg6_r  <= neg5_r;
      r2_6_r  <= r2_6_nxt;
    end
  end

  // The leading term of the series is the reduced angle itself.
  always_comb begin
    beat_o.valid = vld_r[NSTG-1];
    beat_o.neg   = neg6_r;
    beat_o.r2    = r2_6_r;
    beat_o.sum   = '0;
    beat_o.term  = TW'(r6_r);
  end

endmodule

// File: rtl/stsc_term.sv
// One series term: next term = ((term * r^2) >> 40) / ((2K)(2K+1)), plus accumulation.
// Depends on stsc_pkg.
module stsc_term
  import stsc_pkg::*;
#(
  parameter int K = 1
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  stsc_beat_t beat_i,
  output stsc_beat_t beat_o
);

  localparam bit               SUB_IN  = ((K - 1) % 2) == 1;
  localparam int               DIVISOR = (2 * K) * (2 * K + 1);
  localparam logic [RMW-1:0]   DIV_C   = RMW'(DIVISOR);
  localparam logic [VW-1:0]    DIV_RCP = VW'((1 << VW) / DIVISOR);
  localparam int               MW      = TW + R2W;

  stsc_beat_t a_nxt, a_r;
  logic signed [SW-1:0]            t_s;
  logic [T_HI_W-1:0]               t_hi;
  logic [T_LO_W-1:0]               t_lo;
  logic [R2_HI_W-1:0]              s_hi;
  logic [R2_LO_W-1:0]              s_lo;
  logic [T_HI_W+R2_HI_W-1:0]       pp_hh_r;
  logic [T_HI_W+R2_LO_W-1:0]       pp_hl_r;
  logic [T_LO_W+R2_HI_W-1:0]       pp_lh_r;
  logic [T_LO_W+R2_LO_W-1:0]       pp_ll_r;
  logic [MW-1:0]                   full_prod;

  stsc_beat_t                      stg_r [0:NDIG];
  logic [PW-1:0]                   dvd_r [0:NDIG-1];
  logic [RMW-1:0]                  rem_r [1:NDIG-1];
  logic [PW-1:0]                   quo_r [1:NDIG];

  // Stage A: add the incoming term into the sum, or subtract it for even K, and form the partial products.
  always_comb begin
    t_s  = signed'({{(SW - TW){1'b0}}, beat_i.term});
    t_hi = beat_i.term[TW-1:T_LO_W];
    t_lo = beat_i.term[T_LO_W-1:0];
    s_hi = beat_i.r2[R2W-1:R2_LO_W];
    s_lo = beat_i.r2[R2_LO_W-1:0];
    a_nxt = beat_i;
    if (SUB_IN) begin
      a_nxt.sum = beat_i.sum - t_s;
    end else begin
      a_nxt.sum = beat_i.sum + t_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.valid <= 1'b0;
    end else if (en) begin
      a_r     <= a_nxt;
      pp_hh_r <= t_hi * s_hi;
      pp_hl_r <= t_hi * s_lo;
      pp_lh_r <= t_lo * s_hi;
      pp_ll_r <= t_lo * s_lo;
    end
  end

  // Stage B: full product, truncated back to Q.40, becomes the dividend.
  assign full_prod = (MW'(pp_hh_r) << (T_LO_W + R2_LO_W)) +
                     (MW'(pp_hl_r) << T_LO_W) +
                     (MW'(pp_lh_r) << R2_LO_W) +
                     MW'(pp_ll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r[0].valid <= 1'b0;
    end else if (en) begin
      stg_r[0] <= a_r;
      dvd_r[0] <= full_prod[FRAC_W +: PW];
    end
  end

  // Division by the constant, one quotient digit per stage.
  for (genvar j = 1; j <= NDIG; j++) begin : g_digit
    logic [RMW-1:0]     rem_prev;
    logic [PW-1:0]      quo_prev;
    logic [VW-1:0]      v;
    logic [2*VW-1:0]    v_prod;
    logic [DW-1:0]      q_est;
    logic [DW+RMW-1:0]  qd_prod;
    logic [RMW:0]       r_est;
    logic               fix;
    logic [DW-1:0]      q_dig;

    if (j == 1) begin : g_first
      assign rem_prev = '0;
      assign quo_prev = '0;
    end else begin : g_next
      assign rem_prev = rem_r[j-1];
      assign quo_prev = quo_r[j-1];
    end

    // The reciprocal estimate is never high and at most one low.
    always_comb begin
      v       = {rem_prev, dvd_r[j-1][PW-1 -: DW]};
      v_prod  = v * DIV_RCP;
      q_est   = v_prod[VW +: DW];
      qd_prod = q_est * DIV_C;
      r_est   = v[RMW:0] - qd_prod[RMW:0];
      fix     = (r_est >= {1'b0, DIV_C});
      q_dig   = fix ? (q_est + 1'b1) : q_est;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[j].valid <= 1'b0;
      end else if (en) begin
        stg_r[j] <= stg_r[j-1];
        quo_r[j] <= {quo_prev[PW-DW-1:0], q_dig};
      end
    end

    // Remainder and remaining dividend are needed only ahead of the last digit.
    if (j < NDIG) begin : g_carry
      logic [RMW-1:0] r_dig;

      assign r_dig = fix ? RMW'(r_est - {1'b0, DIV_C}) : r_est[RMW-1:0];

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= r_dig;
          dvd_r[j] <= dvd_r[j-1] << DW;
        end
      end
    end
  end

  // The finished quotient is the new term.
  always_comb begin
    beat_o      = stg_r[NDIG];
    beat_o.term = quo_r[NDIG][TW-1:0];
  end

endmodule

// File: rtl/stsc_final.sv
// Back end: last accumulation, rounding to Q1.30, saturation and sign of the result.
// Depends on stsc_pkg.
module stsc_final
  import stsc_pkg::*;
#(
  parameter int N_TERMS = 10
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  stsc_beat_t               beat_i,
  output logic                     fin_valid,
  output logic signed [SINE_W-1:0] fin_value
);

  localparam bit SUB_LAST = (N_TERMS % 2) == 1;
  localparam int QW       = SW - ROUND_SHIFT;

  logic [2:0]               vld_r;
  logic signed [SW-1:0]     t_s;
  logic signed [SW-1:0]     sum1_nxt, sum1_r;
  logic                     neg1_r;
  logic [SW-1:0]            sum_u;
  logic [SW-1:0]            rnd2_nxt, rnd2_r;
  logic                     nego2_r;
  logic [QW-1:0]            q3;
  logic                     over3;
  logic [SINE_W-1:0]        mag3;
  logic [SINE_W-1:0]        val3_nxt, val3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], beat_i.valid};
    end
  end

  // Stage 1: fold in the last term.
  always_comb begin
    t_s = signed'({{(SW - TW){1'b0}}, beat_i.term});
    if (SUB_LAST) begin
      sum1_nxt = beat_i.sum - t_s;
    end else begin
      sum1_nxt = beat_i.sum + t_s;
    end
  end

  // Stage 2: magnitude of the sum with half an output LSB added.
  assign sum_u    = sum1_r;
  assign rnd2_nxt = sum_u[SW-1] ? (SW'(ROUND_HALF) - sum_u) : (sum_u + SW'(ROUND_HALF));

  // Stage 3: drop to Q1.30, clip at one and apply the combined sign.
  always_comb begin
    q3       = rnd2_r[SW-1:ROUND_SHIFT];
    over3    = q3 > QW'(ONE_Q30);
    mag3     = over3 ? ONE_Q30 : q3[SINE_W-1:0];
    val3_nxt = nego2_r ? (SINE_W'(0) - mag3) : mag3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1_r  <= sum1_nxt;
      neg1_r  <= beat_i.neg;
      rnd2_r  <= rnd2_nxt;
      nego2_r <= sum_u[SW-1] ^ neg1_r;
      val3_r  <= val3_nxt;
    end
  end

  assign fin_valid = vld_r[2];
  assign fin_value = val3_r;

endmodule

// File: rtl/sine_taylor_series_core.sv
// Sine of a Q16.16 angle as Q1.30 by reduction modulo two pi and a Taylor series.
// Throughput: one transaction per cycle while the skid register is empty; six pipeline stages
// per series term, six for reduction and squaring, three for rounding, then the output register.
// Reset: rst_n, synchronous and active low, clears all valid bits; nothing else is reset.
`include "sine_taylor_series_core_defines.svh"

module sine_taylor_series_core
  import stsc_pkg::*;
#(
  parameter int SERIES_TERMS = 10
)
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] in_angle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SINE_W-1:0]  out_sine_value
);

  localparam logic signed [SINE_W-1:0] SINE_MAX = ONE_Q30;
  localparam logic signed [SINE_W-1:0] SINE_MIN = SINE_W'(0) - ONE_Q30;

  logic                     en;
  stsc_beat_t               chain [0:SERIES_TERMS];
  logic                     fin_valid;
  logic signed [SINE_W-1:0] fin_value;

  logic                     out_valid_nxt, out_valid_r;
  logic signed [SINE_W-1:0] out_data_nxt, out_data_r;
  logic                     skid_valid_nxt, skid_valid_r;
  logic signed [SINE_W-1:0] skid_data_nxt, skid_data_r;

  // The whole pipeline advances while the skid register is empty.
  assign en       = !skid_valid_r;
  assign in_ready = en;

  // Reduction and square.
  stsc_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_angle (in_angle),
    .beat_o   (chain[0])
  );

  // One unit per series term.
  for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
    stsc_term #(
      .K (k)
    ) u_term (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .beat_i (chain[k-1]),
      .beat_o (chain[k])
    );
  end

  // Rounding, saturation and sign.
  stsc_final #(
    .N_TERMS (SERIES_TERMS)
  ) u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .beat_i    (chain[SERIES_TERMS]),
    .fin_valid (fin_valid),
    .fin_value (fin_value)
  );

  // Output register with a skid stage behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = fin_valid;
        out_data_nxt  = fin_value;
      end
    end else if (en && fin_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = fin_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sine_value = out_data_r;

  // The skid stage only fills behind a full output register.
  `STSC_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with empty output")
  // A stalled output with a result arriving closes the input in the next cycle.
  `STSC_ASSERT_NEXT(a_stall_closes_in, out_valid_r && !out_ready && fin_valid, !in_ready, "input open after stall")
  // A waiting skid transaction moves to the output as soon as the output is taken.
  `STSC_ASSERT_NEXT(a_skid_drains, skid_valid_r && out_ready, out_valid_r && !skid_valid_r, "skid not drained")
  // Results are saturated to plus or minus one.
  `STSC_ASSERT_NOW(a_sine_range, out_valid_r, (out_data_r <= SINE_MAX) && (out_data_r >= SINE_MIN), "sine out of range")

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for sine_taylor_series_core: Q16.16 angles in, Q1.30 sines out.
// Depends on stsc_pkg and the core RTL; predicts every sine with its own series evaluator.
module tb_top;

  localparam int          N_TERMS      = 10;
  localparam int          AW           = stsc_pkg::ANGLE_W;
  localparam int          OW           = stsc_pkg::SINE_W;
  localparam logic [63:0] PI_Q60_C     = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] TWO_PI_Q40_C = ((PI_Q60_C >> 18) + 64'd1) >> 1;
  localparam logic [63:0] UNITY_Q30    = 64'h4000_0000;
  localparam int          N_RANDOM     = 600;
  localparam int          CALM_TAIL    = 60;
  localparam int          DRAIN_CYCLES = 6 * N_TERMS + 20;
  localparam int          CYCLE_LIMIT  = 100000;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic signed [AW-1:0] in_angle       = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic signed [OW-1:0] out_sine_value;

  // Angles waiting to be driven and sines waiting to come out.
  logic signed [AW-1:0] angle_queue[$];
  logic signed [OW-1:0] sine_expect[$];

  int  mismatch_count = 0;
  int  accepted_count = 0;
  int  checked_count  = 0;
  int  cycle_count    = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  bit  idle_ok        = 1'b0;

  sine_taylor_series_core #(
    .SERIES_TERMS(N_TERMS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_angle      (in_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sine_value(out_sine_value)
  );

  always #4 clk = ~clk;

  // Range-reduce the magnitude modulo two pi in Q.40, sum the alternating series, round to
  // Q1.30 with saturation and apply the sign of the angle combined with the sign of the sum.
  function automatic logic signed [OW-1:0] taylor_sine(logic signed [AW-1:0] angle);
    logic               neg_in;
    logic               neg_sum;
    logic [31:0]        a_bits;
    logic [63:0]        mag;
    logic [63:0]        red;
    logic [63:0]        r_sq;
    logic [63:0]        term;
    logic [63:0]        divisor;
    logic [63:0]        smag;
    logic [63:0]        q30;
    logic [63:0]        acc;
    logic [127:0]       prod;
    a_bits = angle;
    neg_in = a_bits[31];
    mag    = {32'd0, neg_in ? (~a_bits + 32'd1) : a_bits};
    red    = (mag << 24) % TWO_PI_Q40_C;
    prod   = {64'd0, red} * {64'd0, red};
    r_sq   = prod[103:40];
    acc    = red;
    term   = red;
    for (int k = 1; k <= N_TERMS; k++) begin
      divisor = 64'(2 * k) * 64'(2 * k + 1);
      prod    = {64'd0, term} * {64'd0, r_sq};
      term    = prod[103:40] / divisor;
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    neg_sum = acc[63];
    smag    = neg_sum ? (~acc + 64'd1) : acc;
    q30     = (smag + 64'd512) >> 10;
    if (q30 > UNITY_Q30) begin
      q30 = UNITY_Q30;
    end
    if (neg_sum != neg_in) begin
      q30 = ~q30 + 64'd1;
    end
    return q30[31:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Driver: records each accepted transaction and presents the next angle,
  // inserting random idle bursts while idling is enabled.
  always @(posedge clk) begin
    logic                 next_valid;
    logic signed [AW-1:0] next_angle;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_angle <= '0;
      idle_ok  <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_angle = in_angle;
      if (in_valid && in_ready) begin
        sine_expect.push_back(taylor_sine(in_angle));
        accepted_count++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left == 0 && idle_ok && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 9);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (angle_queue.size() > 0) begin
          next_valid = 1'b1;
          next_angle = angle_queue.pop_front();
        end
      end
      in_valid <= next_valid;
      in_angle <= next_angle;
      // Every fourth stretch of 64 transactions runs without idling, as does the tail.
      idle_ok  <= (angle_queue.size() > CALM_TAIL) && ((accepted_count / 64) % 4 != 3);
    end
  end

  // Monitor: compares each accepted sine against the oldest prediction and
  // stalls the result channel in random bursts.
  always @(posedge clk) begin
    logic next_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sine_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected sine_value %0d", out_sine_value));
        end else begin
          if (out_sine_value !== sine_expect[0]) begin
            report_mismatch($sformatf("sine_value got %0d expected %0d",
                                      out_sine_value, sine_expect[0]));
          end
          void'(sine_expect.pop_front());
          checked_count++;
        end
      end
      next_ready = 1'b1;
      if (stall_left == 0 && idle_ok && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end
      out_ready <= next_ready;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus: directed corner angles, then a random mix, then drain and verdict.
  initial begin
    int                   pick;
    int                   quad;
    logic signed [AW-1:0] a;
    angle_queue = '{
      32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
      32'sd65536, -32'sd65536, 32'sd102944, 32'sd102943, -32'sd102944,
      32'sd205887, -32'sd205887, 32'sd308831, 32'sd411775, 32'sd411774,
      32'sd411776, -32'sd411775, 32'sd393216, 32'sd327680, 32'sh7FFF_0000,
      32'sd256, 32'sh4000_0000, 32'shC000_0000, 32'sh5555_5555, 32'shAAAA_AAAA
    };
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        // Any 32-bit angle.
        a = $urandom;
      end else if (pick < 7) begin
        // Within about eight radians either side of zero.
        a = $signed($urandom_range(0, 1048576)) - 32'sd524288;
      end else if (pick < 9) begin
        // Close to a multiple of a quarter turn, where the sine peaks or crosses zero.
        quad = $signed($urandom_range(0, 80)) - 40;
        a    = quad * 102944 + ($signed($urandom_range(0, 64)) - 32);
      end else begin
        // Near the largest magnitudes of either sign.
        a = {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom)};
      end
      angle_queue.push_back(a);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (angle_queue.size() != 0 || in_valid) @(posedge clk);
    while (sine_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d sines from %0d angles: corner angles, quadrant edges,",
             checked_count, accepted_count);
    $display("full-range and small-range random angles, with idle and stall bursts.");
    if (mismatch_count == 0 && sine_expect.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d sines still awaited", mismatch_count,
               sine_expect.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/stsc_pkg.sv
rtl/stsc_reduce.sv
rtl/stsc_term.sv
rtl/stsc_final.sv
rtl/sine_taylor_series_core.sv
sim/tb_top.sv
